>>> rtl/core/lcab_pkg.sv
// Package for the binary-lifting lowest common ancestor block.
// Holds sizes, the request and result types, memory entry and access types
// and small helper functions. Depends on nothing.
package lcab_pkg;

	localparam int MAX_NODES     = 1024;
	localparam int NODE_BITS     = $clog2(MAX_NODES);
	localparam int LEVELS        = 10;
	localparam int LEVEL_BITS    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int KCNT_BITS     = $clog2(LEVELS + 1);
	localparam int COST_BITS     = 16;
	localparam int DIST_BITS     = 26;
	localparam int DEPTH_BITS    = 10;
	localparam int CFG_BITS      = 11;
	localparam int ANC_DEPTH     = LEVELS * MAX_NODES;
	localparam int ANC_ADDR_BITS = LEVEL_BITS + NODE_BITS;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_BUILD = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef struct packed {
		action_t                action;
		logic [NODE_BITS-1:0]   node_a;
		logic [NODE_BITS-1:0]   node_b;
		logic [NODE_BITS-1:0]   parent_node;
		logic                   is_root;
		logic [COST_BITS-1:0]   edge_cost;
	} lca_in_t;

	typedef struct packed {
		logic [NODE_BITS-1:0]   common_ancestor;
		logic [DIST_BITS-1:0]   path_distance;
	} lca_out_t;

	typedef struct packed {
		logic                   has;
		logic [NODE_BITS-1:0]   node;
	} anc_entry_t;

	typedef struct packed {
		logic [DEPTH_BITS-1:0]  depth;
		logic [DIST_BITS-1:0]   root_dist;
	} node_entry_t;

	typedef struct packed {
		logic                      re;
		logic [ANC_ADDR_BITS-1:0]  raddr;
		logic                      we;
		logic [ANC_ADDR_BITS-1:0]  waddr;
		anc_entry_t                wdata;
	} anc_req_t;

	typedef struct packed {
		logic                   re;
		logic [NODE_BITS-1:0]   raddr;
		logic                   we;
		logic [NODE_BITS-1:0]   waddr;
		node_entry_t            wdata;
	} node_req_t;

	// Ancestor memory is laid out level by level, each level a full node range.
	function automatic logic [ANC_ADDR_BITS-1:0] anc_addr(input logic [LEVEL_BITS-1:0] lv,
			input logic [NODE_BITS-1:0] n);
		return {lv, n};
	endfunction

	// Smallest K >= 1 with 2^K >= node count, capped at LEVELS.
	function automatic logic [KCNT_BITS-1:0] level_count(input logic [CFG_BITS-1:0] nc);
		logic [KCNT_BITS-1:0] k;
		k = KCNT_BITS'(1);
		for (int i = 1; i < LEVELS; i++) begin
			if ((1 << i) < int'(nc)) begin
				k = KCNT_BITS'(i + 1);
			end
		end
		return k;
	endfunction

endpackage

>>> rtl/core/lcab_ram.sv
// Generic simple dual-port synchronous RAM: one write port, one read port,
// read data registered. Depends on nothing.
module lcab_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8,
	localparam int ADDR_BITS = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/lcab_seq.sv
// Sequencer for load, table build and query requests. Drives the ancestor
// and node memories and forms the result. Depends on lcab_pkg.
module lcab_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  lcab_pkg::lca_in_t           req,
	input  logic [lcab_pkg::KCNT_BITS-1:0] levels,
	output logic                        done,
	output lcab_pkg::lca_out_t          result,
	output lcab_pkg::anc_req_t          anc_req,
	input  lcab_pkg::anc_entry_t        anc_rdata,
	output lcab_pkg::node_req_t         node_req,
	input  lcab_pkg::node_entry_t       node_rdata
);
	import lcab_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE    = 18'd1 << 0,
		S_L_ISSUE = 18'd1 << 1,
		S_L_WR    = 18'd1 << 2,
		S_B_RD    = 18'd1 << 3,
		S_B_PAR   = 18'd1 << 4,
		S_B_WR    = 18'd1 << 5,
		S_Q_RDU   = 18'd1 << 6,
		S_Q_RDV   = 18'd1 << 7,
		S_Q_SW    = 18'd1 << 8,
		S_Q_LIFT  = 18'd1 << 9,
		S_Q_LIFTW = 18'd1 << 10,
		S_Q_JA    = 18'd1 << 11,
		S_Q_JB    = 18'd1 << 12,
		S_Q_JC    = 18'd1 << 13,
		S_Q_FIN   = 18'd1 << 14,
		S_Q_FINW  = 18'd1 << 15,
		S_Q_DIST  = 18'd1 << 16,
		S_Q_OUT   = 18'd1 << 17
	} state_t;

	state_t state_q, state_d;

	lca_in_t                req_q;
	logic [KCNT_BITS-1:0]   k_q;
	logic [NODE_BITS-1:0]   bv_q;
	logic                   par_has_q;
	logic [NODE_BITS-1:0]   un_q;
	logic [NODE_BITS-1:0]   vn_q;
	logic [NODE_BITS-1:0]   w_q;
	logic [DEPTH_BITS-1:0]  du_q;
	logic [DEPTH_BITS-1:0]  diff_q;
	logic [DIST_BITS:0]     sum_q;
	anc_entry_t             a_q;
	logic                   done_q;
	lca_out_t               result_q;

	logic                   accept;
	logic [LEVEL_BITS-1:0]  k_idx;
	logic [LEVEL_BITS-1:0]  k_next_idx;
	logic                   lift_bit;
	logic                   build_last;
	logic [DIST_BITS:0]     load_sum;
	logic [DIST_BITS:0]     twice_w;
	logic [DIST_BITS:0]     dist_diff;
	logic [DIST_BITS-1:0]   path_dist;

	assign accept     = start && (state_q == S_IDLE);
	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign result     = result_q;
	assign k_idx      = k_q[LEVEL_BITS-1:0];
	assign k_next_idx = LEVEL_BITS'(k_idx + 1'b1);
	assign lift_bit   = |(diff_q & (DEPTH_BITS'(1) << k_idx));
	// The build stops once level k+1 is the top level in use.
	assign build_last = ({1'b0, k_q} + (KCNT_BITS+1)'(2)) >= {1'b0, levels};
	assign load_sum   = {1'b0, node_rdata.root_dist} + (DIST_BITS+1)'(req_q.edge_cost);
	assign twice_w    = {node_rdata.root_dist, 1'b0};
	assign dist_diff  = sum_q - twice_w;

	always_comb begin
		if (sum_q < twice_w) begin
			path_dist = '0;
		end else if (dist_diff[DIST_BITS]) begin
			path_dist = {DIST_BITS{1'b1}};
		end else begin
			path_dist = dist_diff[DIST_BITS-1:0];
		end
	end

	// Memory accesses issued in each state.
	always_comb begin
		anc_req  = '0;
		node_req = '0;
		unique case (state_q)
			S_L_ISSUE: begin
				if (req_q.is_root) begin
					node_req.we   = 1'b1;
					node_req.waddr = req_q.node_a;
					anc_req.we    = 1'b1;
					anc_req.waddr = anc_addr('0, req_q.node_a);
				end else begin
					node_req.re    = 1'b1;
					node_req.raddr = req_q.parent_node;
				end
			end
			S_L_WR: begin
				node_req.we              = 1'b1;
				node_req.waddr           = req_q.node_a;
				node_req.wdata.depth     = DEPTH_BITS'(node_rdata.depth + 1'b1);
				node_req.wdata.root_dist = load_sum[DIST_BITS] ? {DIST_BITS{1'b1}}
				                                               : load_sum[DIST_BITS-1:0];
				anc_req.we               = 1'b1;
				anc_req.waddr            = anc_addr('0, req_q.node_a);
				anc_req.wdata.has        = 1'b1;
				anc_req.wdata.node       = req_q.parent_node;
			end
			S_B_RD: begin
				anc_req.re    = 1'b1;
				anc_req.raddr = anc_addr(k_idx, bv_q);
			end
			S_B_PAR: begin
				anc_req.re    = 1'b1;
				anc_req.raddr = anc_addr(k_idx, anc_rdata.node);
			end
			S_B_WR: begin
				anc_req.we    = 1'b1;
				anc_req.waddr = anc_addr(k_next_idx, bv_q);
				anc_req.wdata = par_has_q ? anc_rdata : '0;
			end
			S_Q_RDU: begin
				node_req.re    = 1'b1;
				node_req.raddr = req_q.node_a;
			end
			S_Q_RDV: begin
				node_req.re    = 1'b1;
				node_req.raddr = req_q.node_b;
			end
			S_Q_LIFT: begin
				if (k_q != levels && lift_bit) begin
					anc_req.re    = 1'b1;
					anc_req.raddr = anc_addr(k_idx, un_q);
				end
			end
			S_Q_JA, S_Q_FIN: begin
				anc_req.re    = 1'b1;
				anc_req.raddr = anc_addr((state_q == S_Q_FIN) ? '0 : k_idx, un_q);
			end
			S_Q_JB: begin
				anc_req.re    = 1'b1;
				anc_req.raddr = anc_addr(k_idx, vn_q);
			end
			S_Q_DIST: begin
				node_req.re    = 1'b1;
				node_req.raddr = w_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (req.action)
						ACT_LOAD:  state_d = S_L_ISSUE;
						ACT_BUILD: state_d = (levels > KCNT_BITS'(1)) ? S_B_RD : S_IDLE;
						ACT_QUERY: state_d = S_Q_RDU;
						ACT_NONE:  state_d = S_IDLE;
					endcase
				end
			end
			S_L_ISSUE: state_d = req_q.is_root ? S_IDLE : S_L_WR;
			S_L_WR:    state_d = S_IDLE;
			S_B_RD:    state_d = S_B_PAR;
			S_B_PAR:   state_d = S_B_WR;
			S_B_WR: begin
				if (bv_q == {NODE_BITS{1'b1}} && build_last) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_B_RD;
				end
			end
			S_Q_RDU:   state_d = S_Q_RDV;
			S_Q_RDV:   state_d = S_Q_SW;
			S_Q_SW:    state_d = S_Q_LIFT;
			S_Q_LIFT: begin
				if (k_q == levels) begin
					state_d = (un_q == vn_q) ? S_Q_DIST : S_Q_JA;
				end else if (lift_bit) begin
					state_d = S_Q_LIFTW;
				end
			end
			S_Q_LIFTW: state_d = S_Q_LIFT;
			S_Q_JA:    state_d = S_Q_JB;
			S_Q_JB:    state_d = S_Q_JC;
			S_Q_JC:    state_d = (k_q == '0) ? S_Q_FIN : S_Q_JA;
			S_Q_FIN:   state_d = S_Q_FINW;
			S_Q_FINW:  state_d = S_Q_DIST;
			S_Q_DIST:  state_d = S_Q_OUT;
			S_Q_OUT:   state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_Q_OUT);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q <= req;
					k_q   <= '0;
					bv_q  <= '0;
				end
			end
			S_B_PAR: par_has_q <= anc_rdata.has;
			S_B_WR: begin
				bv_q <= NODE_BITS'(bv_q + 1'b1);
				if (bv_q == {NODE_BITS{1'b1}}) begin
					k_q <= KCNT_BITS'(k_q + 1'b1);
				end
			end
			S_Q_RDV: begin
				du_q  <= node_rdata.depth;
				sum_q <= {1'b0, node_rdata.root_dist};
			end
			S_Q_SW: begin
				// Lift the deeper node; the distance sum does not care which is which.
				sum_q <= sum_q + {1'b0, node_rdata.root_dist};
				k_q   <= '0;
				if (du_q < node_rdata.depth) begin
					un_q   <= req_q.node_b;
					vn_q   <= req_q.node_a;
					diff_q <= DEPTH_BITS'(node_rdata.depth - du_q);
				end else begin
					un_q   <= req_q.node_a;
					vn_q   <= req_q.node_b;
					diff_q <= DEPTH_BITS'(du_q - node_rdata.depth);
				end
			end
			S_Q_LIFT: begin
				if (k_q == levels) begin
					w_q <= un_q;
					k_q <= KCNT_BITS'(levels - 1'b1);
				end else if (!lift_bit) begin
					k_q <= KCNT_BITS'(k_q + 1'b1);
				end
			end
			S_Q_LIFTW: begin
				if (anc_rdata.has) begin
					un_q <= anc_rdata.node;
				end
				k_q <= KCNT_BITS'(k_q + 1'b1);
			end
			S_Q_JB: a_q <= anc_rdata;
			S_Q_JC: begin
				// Both move only when both ancestors exist and still differ.
				if (a_q != anc_rdata && a_q.has && anc_rdata.has) begin
					un_q <= a_q.node;
					vn_q <= anc_rdata.node;
				end
				if (k_q != '0) begin
					k_q <= KCNT_BITS'(k_q - 1'b1);
				end
			end
			S_Q_FINW: w_q <= anc_rdata.has ? anc_rdata.node : un_q;
			S_Q_OUT: begin
				result_q.common_ancestor <= w_q;
				result_q.path_distance   <= path_dist;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/core/lca_binary_lifting.sv
// Top level of the binary-lifting lowest common ancestor block.
// Holds the level-count register and the two memories around lcab_seq.
// Depends on lcab_pkg, lcab_ram and lcab_seq.
//
//   channel   handshake           payload
//   request   start / busy        req (lca_in_t)
//   result    done strobe         result (lca_out_t)
//   config    cfg_valid/cfg_ready cfg_data (node count)
//
// A request is taken when start is high and busy is low. Busy then stays high until
// the load, build or query is through, so no new request is taken before then;
// each lifting step waits on one read of the single ancestor memory port. A query
// result shows on result for the one cycle that done is high, the cycle in which
// busy falls; the receiver cannot stall it.
// Reset clears control state only; no memory is cleared and no clearing pass runs.
module lca_binary_lifting (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  lcab_pkg::lca_in_t                req,
	output logic                             done,
	output lcab_pkg::lca_out_t               result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lcab_pkg::CFG_BITS-1:0]    cfg_data
);
	import lcab_pkg::*;

	logic [KCNT_BITS-1:0]               levels_q;
	anc_req_t                           anc_req;
	node_req_t                          node_req;
	logic [$bits(anc_entry_t)-1:0]      anc_rdata_raw;
	logic [$bits(node_entry_t)-1:0]     node_rdata_raw;
	anc_entry_t                         anc_rdata;
	node_entry_t                        node_rdata;

	assign cfg_ready  = 1'b1;
	assign anc_rdata  = anc_entry_t'(anc_rdata_raw);
	assign node_rdata = node_entry_t'(node_rdata_raw);

	// Only the lifting level count derived from the node count is kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= level_count(CFG_BITS'(MAX_NODES));
		end else if (cfg_valid && cfg_ready) begin
			levels_q <= level_count(cfg_data);
		end
	end

	lcab_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.levels     (levels_q),
		.done       (done),
		.result     (result),
		.anc_req    (anc_req),
		.anc_rdata  (anc_rdata),
		.node_req   (node_req),
		.node_rdata (node_rdata)
	);

	lcab_ram #(
		.DEPTH (ANC_DEPTH),
		.WIDTH ($bits(anc_entry_t))
	) u_anc_ram (
		.clk   (clk),
		.re    (anc_req.re),
		.raddr (anc_req.raddr),
		.rdata (anc_rdata_raw),
		.we    (anc_req.we),
		.waddr (anc_req.waddr),
		.wdata (anc_req.wdata)
	);

	lcab_ram #(
		.DEPTH (MAX_NODES),
		.WIDTH ($bits(node_entry_t))
	) u_node_ram (
		.clk   (clk),
		.re    (node_req.re),
		.raddr (node_req.raddr),
		.rdata (node_rdata_raw),
		.we    (node_req.we),
		.waddr (node_req.waddr),
		.wdata (node_req.wdata)
	);

endmodule

>>> bench/lca_answer_check.sv
// Checker for the lowest common ancestor block: watches the request, result and
// node-count channels, keeps its own copy of the tree stores and compares answers.
// Depends on lcab_pkg.
module lca_answer_check
	import lcab_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  lca_in_t               req,
	input  logic                  done,
	input  lca_out_t              result,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_BITS-1:0]   cfg_data,
	output int                    mismatches,
	output int                    answers_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint DIST_TOP = (longint'(1) << DIST_BITS) - 1;

	anc_entry_t             hops [LEVELS][MAX_NODES];
	logic [DEPTH_BITS-1:0]  depth_of [MAX_NODES];
	logic [DIST_BITS-1:0]   dist_of [MAX_NODES];
	logic [CFG_BITS-1:0]    node_cnt;
	lca_out_t               answers_due [$];
	lca_out_t               want;

	function automatic int lifting_levels();
		int k;
		k = 1;
		while (k < LEVELS && (1 << k) < int'(node_cnt)) begin
			k++;
		end
		return k;
	endfunction

	// Depth and distance come from the parent, so the parent is read before the
	// node itself is overwritten (a node may name itself as parent).
	function automatic void store_node(lca_in_t r);
		logic [NODE_BITS-1:0] p;
		logic [DIST_BITS:0]   sum;
		if (r.is_root) begin
			hops[0][r.node_a] = '0;
			depth_of[r.node_a] = '0;
			dist_of[r.node_a] = '0;
		end else begin
			p = r.parent_node;
			sum = dist_of[p] + r.edge_cost;
			hops[0][r.node_a] = '{has: 1'b1, node: p};
			depth_of[r.node_a] = depth_of[p] + 1'b1;
			dist_of[r.node_a] = sum[DIST_BITS] ? '1 : sum[DIST_BITS-1:0];
		end
	endfunction

	function automatic void fill_hops();
		int k_use;
		anc_entry_t e;
		k_use = lifting_levels();
		for (int k = 0; k + 1 < k_use; k++) begin
			for (int v = 0; v < MAX_NODES; v++) begin
				e = hops[k][v];
				hops[k+1][v] = e.has ? hops[k][e.node] : '0;
			end
		end
	endfunction

	function automatic logic [NODE_BITS-1:0] meet_point(logic [NODE_BITS-1:0] a,
			logic [NODE_BITS-1:0] b);
		logic [NODE_BITS-1:0]  u;
		logic [NODE_BITS-1:0]  v;
		logic [DEPTH_BITS-1:0] gap;
		anc_entry_t            x;
		anc_entry_t            y;
		int                    k_use;
		k_use = lifting_levels();
		u = a;
		v = b;
		if (depth_of[u] < depth_of[v]) begin
			u = b;
			v = a;
		end
		gap = depth_of[u] - depth_of[v];
		for (int k = 0; k < k_use; k++) begin
			if (gap[k] && hops[k][u].has) begin
				u = hops[k][u].node;
			end
		end
		if (u == v) begin
			return u;
		end
		// Both climb together only where both ancestors exist and differ.
		for (int k = k_use - 1; k >= 0; k--) begin
			x = hops[k][u];
			y = hops[k][v];
			if (x != y && x.has && y.has) begin
				u = x.node;
				v = y.node;
			end
		end
		return hops[0][u].has ? hops[0][u].node : u;
	endfunction

	function automatic lca_out_t answer_for(lca_in_t r);
		lca_out_t             ans;
		logic [NODE_BITS-1:0] w;
		longint               d;
		w = meet_point(r.node_a, r.node_b);
		d = longint'(dist_of[r.node_a]) + longint'(dist_of[r.node_b])
			- 2 * longint'(dist_of[w]);
		if (d < 0) begin
			d = 0;
		end
		if (d > DIST_TOP) begin
			d = DIST_TOP;
		end
		ans.common_ancestor = w;
		ans.path_distance = d[DIST_BITS-1:0];
		return ans;
	endfunction

	function automatic void take_request(lca_in_t r);
		case (r.action)
			ACT_LOAD:  store_node(r);
			ACT_BUILD: fill_hops();
			ACT_QUERY: answers_due.push_back(answer_for(r));
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_cnt = CFG_BITS'(MAX_NODES);
			answers_due.delete();
			answers_pending = 0;
			mismatches = 0;
		end else begin
			if (done) begin
				if (answers_due.size() == 0) begin
					$error("result with no query waiting: common_ancestor %0d, path_distance %0d",
						result.common_ancestor, result.path_distance);
					mismatches++;
				end else begin
					want = answers_due.pop_front();
					if (result.common_ancestor !== want.common_ancestor) begin
						$error("common_ancestor: expected %0d, got %0d",
							want.common_ancestor, result.common_ancestor);
						mismatches++;
					end
					if (result.path_distance !== want.path_distance) begin
						$error("path_distance: expected %0d, got %0d",
							want.path_distance, result.path_distance);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				node_cnt = cfg_data;
			end
			if (start && !busy) begin
				take_request(req);
			end
			answers_pending = answers_due.size();
		end
	end

endmodule

>>> bench/tb.sv
// Top of the lowest common ancestor testbench: clock, reset, request and node-count
// stimulus, and the verdict. Depends on lcab_pkg, lca_binary_lifting and
// lca_answer_check.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lcab_pkg::*;

	localparam int     BUILD_WAIT  = 3 * MAX_NODES * LEVELS + 64;
	localparam int     CYCLE_LIMIT = 3_000_000;
	localparam int     PHASE_ITEMS = 740;
	localparam int     CFG_STEPS [14] = '{0, 1, 2, 3, 4, 5, 9, 17, 33, 100, 513, 1024,
		1025, 2047};

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	lca_in_t               req;
	logic                  done;
	lca_out_t              result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_BITS-1:0]   cfg_data;
	int                    mismatches;
	int                    answers_pending;

	int  up_of [MAX_NODES];
	int  kids [MAX_NODES];
	int  plant_order [MAX_NODES];
	bit  quiet;
	bit  last_build;
	int  ticks = 0;

	lca_binary_lifting dut (
		.clk, .arst_n, .start, .busy, .req, .done, .result,
		.cfg_valid, .cfg_ready, .cfg_data
	);

	lca_answer_check chk (
		.clk, .arst_n, .start, .busy, .req, .done, .result,
		.cfg_valid, .cfg_ready, .cfg_data,
		.mismatches(mismatches), .answers_pending(answers_pending)
	);

	initial begin
		clk = 1'b0;
	end

	always #2 clk = ~clk;

	always @(posedge clk) begin
		ticks++;
		if (ticks > CYCLE_LIMIT) begin
			$display("lca_binary_lifting test failed");
			$finish;
		end
	end

	function automatic lca_in_t noise_fields();
		logic [63:0] raw;
		lca_in_t     r;
		raw = {$urandom, $urandom};
		r = raw[$bits(lca_in_t)-1:0];
		return r;
	endfunction

	function automatic int any_cost();
		int pick;
		pick = $urandom_range(9, 0);
		if (pick == 0) begin
			return 0;
		end
		if (pick == 1) begin
			return 65535;
		end
		return $urandom_range(65535, 0);
	endfunction

	// A request waits with start high until busy is seen low at a rising edge.
	task automatic send(input lca_in_t r);
		int gap;
		if (!quiet && $urandom_range(99, 0) < 14) begin
			gap = $urandom_range(8, 1);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		last_build = (r.action == ACT_BUILD);
	endtask

	// Wait until every answer is in; a build gives none, so allow for one still running.
	task automatic settle();
		int pause;
		@(negedge clk);
		start <= 1'b0;
		while (answers_pending != 0) @(negedge clk);
		pause = last_build ? BUILD_WAIT : 64;
		repeat (pause) @(negedge clk);
		last_build = 1'b0;
	endtask

	task automatic set_node_count(input int n);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= CFG_BITS'(n);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic link(input int a, input int p);
		if (up_of[a] >= 0) begin
			kids[up_of[a]]--;
		end
		up_of[a] = p;
		if (p >= 0) begin
			kids[p]++;
		end
	endtask

	task automatic load_node(input int a, input int p, input bit root, input int cost);
		lca_in_t r;
		r = noise_fields();
		r.action = ACT_LOAD;
		r.node_a = NODE_BITS'(a);
		r.parent_node = NODE_BITS'(p);
		r.is_root = root;
		r.edge_cost = COST_BITS'(cost);
		link(a, root ? -1 : p);
		send(r);
	endtask

	task automatic query_item(input int a, input int b);
		lca_in_t r;
		r = noise_fields();
		r.action = ACT_QUERY;
		r.node_a = NODE_BITS'(a);
		r.node_b = NODE_BITS'(b);
		send(r);
	endtask

	task automatic build_item();
		lca_in_t r;
		r = noise_fields();
		r.action = ACT_BUILD;
		send(r);
	endtask

	task automatic idle_item();
		lca_in_t r;
		r = noise_fields();
		r.action = ACT_NONE;
		send(r);
	endtask

	// Loads every node in a shuffled order, each parent before its children.
	// chain_pct sets how often a node hangs under the one loaded just before it.
	task automatic plant_tree(input int chain_pct, input bit heavy);
		int j;
		int t;
		int p;
		for (int i = 0; i < MAX_NODES; i++) begin
			plant_order[i] = i;
			up_of[i] = -1;
			kids[i] = 0;
		end
		for (int i = MAX_NODES - 1; i > 0; i--) begin
			j = $urandom_range(i, 0);
			t = plant_order[i];
			plant_order[i] = plant_order[j];
			plant_order[j] = t;
		end
		load_node(plant_order[0], $urandom_range(1023, 0), 1'b1, any_cost());
		for (int i = 1; i < MAX_NODES; i++) begin
			if ($urandom_range(99, 0) < chain_pct) begin
				p = plant_order[i-1];
			end else begin
				p = plant_order[$urandom_range(i - 1, 0)];
			end
			load_node(plant_order[i], p, 1'b0, heavy ? 65535 : any_cost());
		end
	endtask

	// Re-hanging a childless node keeps every stored depth and distance consistent.
	task automatic move_leaf(input bit as_root);
		int a;
		int p;
		int tries;
		a = $urandom_range(1023, 0);
		tries = 0;
		while (kids[a] != 0 && tries < 64) begin
			a = $urandom_range(1023, 0);
			tries++;
		end
		do p = $urandom_range(1023, 0); while (p == a);
		load_node(a, p, as_root, any_cost());
	endtask

	task automatic query_pair();
		int a;
		int b;
		int steps;
		a = $urandom_range(1023, 0);
		if ($urandom_range(1, 0)) begin
			b = $urandom_range(1023, 0);
		end else begin
			b = a;
			steps = $urandom_range(40, 0);
			while (steps > 0 && up_of[b] >= 0 && up_of[b] != b) begin
				b = up_of[b];
				steps--;
			end
		end
		if ($urandom_range(1, 0)) begin
			query_item(a, b);
		end else begin
			query_item(b, a);
		end
	endtask

	initial begin
		int spent;
		int idx;
		int span;
		int pick;
		int root;
		int mid;
		int tail;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		quiet = 1'b0;
		last_build = 1'b0;
		for (int i = 0; i < MAX_NODES; i++) begin
			up_of[i] = -1;
			kids[i] = 0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Small forest with one lifting level: only the loaded nodes are ever read.
		set_node_count(2);
		load_node(0, 1023, 1'b1, 65535);
		load_node(1, 0, 1'b0, 0);
		load_node(2, 1, 1'b0, 0);
		load_node(3, 1, 1'b0, 0);
		load_node(1023, 0, 1'b1, 0);
		load_node(4, 1023, 1'b0, 65535);
		query_item(2, 3);
		// Heavier edge above two children leaves their distances stale, so the
		// path length goes below zero and is clamped.
		load_node(1, 0, 1'b0, 65535);
		query_item(2, 3);
		query_item(4, 2);
		query_item(0, 1023);
		query_item(1023, 1023);
		idle_item();
		query_item(4, 4);
		query_item(3, 0);

		// One long chain of maximum-cost edges reaches the depth wrap once its last node
		// is hung under itself, and the distance saturation when it is hung there again.
		set_node_count(1024);
		plant_tree(100, 1'b1);
		build_item();
		root = plant_order[0];
		mid = plant_order[511];
		tail = plant_order[MAX_NODES-1];
		query_item(tail, root);
		query_item(mid, tail);
		query_item(tail, mid);
		query_item(plant_order[1022], plant_order[1021]);
		load_node(tail, tail, 1'b0, 65535);
		query_item(tail, root);
		load_node(tail, tail, 1'b0, 65535);
		build_item();
		query_item(tail, root);
		query_item(plant_order[1022], tail);
		query_item(tail, mid);

		spent = 0;
		idx = 0;
		while (spent < PHASE_ITEMS) begin
			set_node_count(idx < 14 ? CFG_STEPS[idx] : $urandom_range(2047, 0));
			quiet = (idx == 5);
			repeat ($urandom_range(6, 0)) begin
				move_leaf($urandom_range(9, 0) == 0);
				spent++;
			end
			build_item();
			spent++;
			span = $urandom_range(80, 30);
			repeat (span) begin
				if ($urandom_range(99, 0) < 3) begin
					settle();
				end
				pick = $urandom_range(999, 0);
				if (pick < 50) begin
					idle_item();
				end else begin
					spent++;
					if (pick < 80) begin
						move_leaf(1'b0);
					end else if (pick < 85) begin
						build_item();
					end else if (pick < 95 && idx >= 12) begin
						load_node($urandom_range(1023, 0), $urandom_range(1023, 0), 1'b0,
							any_cost());
					end else begin
						query_pair();
					end
				end
			end
			idx++;
		end

		quiet = 1'b0;
		settle();
		if (mismatches == 0) begin
			$display("lca_binary_lifting test passed");
		end else begin
			$display("lca_binary_lifting test failed");
		end
		$finish;
	end

endmodule
